[hdl/mo1d_pkg.sv]
`default_nettype none

package mo1d_pkg;

   localparam int WINDOW_RADIUS = 2;
   localparam int LINE_LEN      = 2 * WINDOW_RADIUS + 1;
   localparam int FLUSH_W       = $clog2(WINDOW_RADIUS + 1);
   localparam int SAMPLE_W      = 16;
   localparam int QUEUE_DEPTH   = 2;
   localparam int COUNT_W       = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [SAMPLE_W-1:0] sample_in;
      logic                frame_end_in;
   } req_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] sample_out;
      logic                frame_end_out;
   } rsp_type;

   // one bin travelling between the two window stages
   typedef struct packed {
      logic [SAMPLE_W-1:0] value;
      logic                last;
   } item_type;

   // contents of one delay line cell
   typedef struct packed {
      logic                valid;
      logic                last;
      logic [SAMPLE_W-1:0] value;
   } cell_type;

   // true when candidate beats the running extreme
   function automatic logic ext_better(input logic [SAMPLE_W-1:0] cand,
                                       input logic [SAMPLE_W-1:0] acc,
                                       input logic                use_max);
      ext_better = use_max ? (cand > acc) : (cand < acc);
   endfunction

endpackage

`default_nettype wire

[hdl/mo1d_cell.sv]
`default_nettype none

module mo1d_cell (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 shift,
   input  mo1d_pkg::cell_type  d_cell,
   output mo1d_pkg::cell_type  q_cell
);
   import mo1d_pkg::*;

   logic                valid_ff;
   logic                last_ff;
   logic [SAMPLE_W-1:0] value_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (shift) begin
         valid_ff <= d_cell.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (shift) begin
         last_ff  <= d_cell.last;
         value_ff <= d_cell.value;
      end
   end

   assign q_cell = '{valid: valid_ff, last: last_ff, value: value_ff};

endmodule

`default_nettype wire

[hdl/mo1d_window.sv]
`default_nettype none

module mo1d_window (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 use_max,
   input  wire                 in_valid,
   output logic                in_ready,
   input  mo1d_pkg::item_type  in_item,
   output logic                out_valid,
   input  wire                 out_ready,
   output mo1d_pkg::item_type  out_item
);
   import mo1d_pkg::*;

   cell_type             line_q [LINE_LEN];
   cell_type             line_d [LINE_LEN];
   logic [FLUSH_W-1:0]   flush_ff, flush_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   item_type             q_ff [QUEUE_DEPTH];
   item_type             q_in [QUEUE_DEPTH];
   logic                 can_shift;
   logic                 take;
   logic                 shift;
   logic                 push;
   logic                 pop;
   logic [SAMPLE_W-1:0]  ext_val;
   item_type             new_item;

   assign can_shift = (count_ff != COUNT_W'(QUEUE_DEPTH));
   assign in_ready  = can_shift && (flush_ff == '0);
   assign take      = in_valid && in_ready;
   // after a frame-last bin, bubbles push the tail through and isolate the next frame
   assign shift     = take || (can_shift && (flush_ff != '0));

   always_comb begin
      line_d[0] = take ? cell_type'{valid: 1'b1, last: in_item.last, value: in_item.value}
                       : cell_type'{valid: 1'b0, last: 1'b0, value: '0};
      for (int i = 1; i < LINE_LEN; i++) begin
         line_d[i] = line_q[i-1];
      end
   end

   for (genvar g = 0; g < LINE_LEN; g++) begin : g_cell
      mo1d_cell u_cell (
         .clock  (clock),
         .reset  (reset),
         .shift  (shift),
         .d_cell (line_d[g]),
         .q_cell (line_q[g])
      );
   end

   // window around the bin that moves into the center on this shift
   always_comb begin
      ext_val = line_d[WINDOW_RADIUS].value;
      for (int i = 0; i < LINE_LEN; i++) begin
         if (line_d[i].valid && ext_better(line_d[i].value, ext_val, use_max)) begin
            ext_val = line_d[i].value;
         end
      end
   end

   assign push     = shift && line_d[WINDOW_RADIUS].valid;
   assign new_item = '{value: ext_val, last: line_d[WINDOW_RADIUS].last};

   always_comb begin
      if (take && in_item.last) begin
         flush_in = FLUSH_W'(WINDOW_RADIUS);
      end else if (shift && (flush_ff != '0)) begin
         flush_in = flush_ff - FLUSH_W'(1);
      end else begin
         flush_in = flush_ff;
      end
   end

   // two-entry output queue, head at index 0
   assign out_valid = (count_ff != '0);
   assign out_item  = q_ff[0];
   assign pop       = out_valid && out_ready;

   always_comb begin
      q_in[0] = q_ff[0];
      q_in[1] = q_ff[1];
      if (pop) begin
         q_in[0] = q_ff[1];
      end
      if (push) begin
         if ((count_ff == COUNT_W'(1)) && !pop) begin
            q_in[1] = new_item;
         end else begin
            q_in[0] = new_item;
         end
      end
      count_in = count_ff + COUNT_W'(push) - COUNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flush_ff <= '0;
         count_ff <= '0;
      end else begin
         flush_ff <= flush_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff[0] <= q_in[0];
      q_ff[1] <= q_in[1];
   end

endmodule

`default_nettype wire

[hdl/morphological_opening_1d.sv]
// rsp_valid for bin k rises when erosion bin k+2, queued at the edge accepting bin
//   k+4, is taken by dilation; the last four bins follow the frame-last request
// throughput: one request per cycle in a frame while the erosion queue has room; a
//   frame-last request holds off req_ready while bubbles flush the erosion line,
//   and the dilation flush overlaps the start of the next frame
// reset: synchronous, clears the cell valid bits, flush counters and queue counts
`default_nettype none

module morphological_opening_1d (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   output logic               req_ready,
   input  mo1d_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  wire                rsp_ready,
   output mo1d_pkg::rsp_type  rsp_data
);
   import mo1d_pkg::*;

   item_type in_item;
   item_type mid_item;
   item_type out_item;
   logic     mid_valid;
   logic     mid_ready;

   assign in_item = '{value: req_data.sample_in, last: req_data.frame_end_in};

   // erosion: minimum over the window
   mo1d_window u_erode (
      .clock     (clock),
      .reset     (reset),
      .use_max   (1'b0),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_item   (in_item),
      .out_valid (mid_valid),
      .out_ready (mid_ready),
      .out_item  (mid_item)
   );

   // dilation: maximum over the window
   mo1d_window u_dilate (
      .clock     (clock),
      .reset     (reset),
      .use_max   (1'b1),
      .in_valid  (mid_valid),
      .in_ready  (mid_ready),
      .in_item   (mid_item),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_item  (out_item)
   );

   assign rsp_data = '{sample_out: out_item.value, frame_end_out: out_item.last};

endmodule

`default_nettype wire
